>>> design/lsaf_pkg.sv
// ----------------------------------------------------------------------------
// lsaf_pkg
// Shared types and constants of the line sensor array feature extractor.
// ----------------------------------------------------------------------------
package lsaf_pkg;

    localparam int SENSOR_COUNT_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int RAW_W      = 8;   // raw sample and level width
    localparam int THR_W      = 11;  // line threshold width
    localparam int POS_W      = 3;   // position field width
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEP = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK_LEVEL          = 8'd0,
        REG_WHITE_LEVEL          = 8'd1,
        REG_BLACK_LINE_THRESHOLD = 8'd2,
        REG_WHITE_LINE_THRESHOLD = 8'd3
    } t_cfg_idx;

    localparam logic [RAW_W-1:0]        BLACK_LEVEL_RST = 8'd0;
    localparam logic [RAW_W-1:0]        WHITE_LEVEL_RST = 8'd255;
    localparam logic signed [THR_W-1:0] BLACK_THR_RST   = 11'sd51;
    localparam logic signed [THR_W-1:0] WHITE_THR_RST   = 11'sd205;

endpackage

>>> design/lsaf_div.sv
// ----------------------------------------------------------------------------
// lsaf_div
// Pipelined unsigned restoring divider, STEP quotient bits per stage.
// ----------------------------------------------------------------------------
module lsaf_div
    import lsaf_pkg::*;
#(
    parameter int NW   = 18,
    parameter int DW   = 9,
    parameter int QB   = 10,
    parameter int STEP = DIV_STEP
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QB-1:0] o_quot,
    output logic          o_ovf    // quotient >= 2**QB
);

    localparam int NST  = (QB + STEP - 1) / STEP;
    localparam int CMPW = NW + DW;

    logic [NW-1:0] r_rem [NST];
    logic [DW-1:0] r_den [NST];
    logic [QB-1:0] r_q   [NST];
    logic          r_ovf [NST];

    logic [NW-1:0] a_rem [NST];
    logic [DW-1:0] a_den [NST];
    logic [QB-1:0] a_q   [NST];
    logic          a_ovf [NST];
    logic [NW-1:0] n_rem [NST];
    logic [QB-1:0] n_q   [NST];

    always_comb begin
        a_rem[0] = i_num;
        a_den[0] = i_den;
        a_q[0]   = '0;
        a_ovf[0] = (CMPW'(i_num) >> QB) >= CMPW'(i_den);
        for (int s = 1; s < NST; s++) begin
            a_rem[s] = r_rem[s-1];
            a_den[s] = r_den[s-1];
            a_q[s]   = r_q[s-1];
            a_ovf[s] = r_ovf[s-1];
        end
    end

    always_comb begin
        int              k;
        logic [CMPW-1:0] rem;
        logic [CMPW-1:0] sub;
        logic [QB-1:0]   q;
        for (int s = 0; s < NST; s++) begin
            rem = CMPW'(a_rem[s]);
            q   = a_q[s];
            for (int j = 0; j < STEP; j++) begin
                k = QB - 1 - s * STEP - j;
                if (k >= 0) begin
                    sub = CMPW'(a_den[s]) << k;
                    if (rem >= sub) begin
                        rem = rem - sub;
                        q   = q | (QB'(1) << k);
                    end
                end
            end
            n_rem[s] = rem[NW-1:0];
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_den[s] <= a_den[s];
                r_ovf[s] <= a_ovf[s];
            end
        end
    end

    assign o_quot = r_q[NST-1];
    assign o_ovf  = r_ovf[NST-1];

endmodule

>>> design/line_sensor_array_features.sv
// ----------------------------------------------------------------------------
// line_sensor_array_features
// Normalizes a frame of raw reflectance samples and extracts extremes,
// line flags and four centroids, one frame per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+---------------------------
//  cfg       | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | one frame of raw samples
//  m_axis    | out | m_axis_tvalid / m_axis_tready | features of one frame
//
//  A new frame is taken every cycle unless the output waits. A frame passes
//  stage A, the normalization divider (LN = ceil((F+2)/4) stages), stages B
//  to E, the centroid divider (LC = ceil((F+4)/4) stages) and the output register.
//  Reset (synchronous, active low) clears valid bits and loads the register
//  reset values. The whole pipeline holds while the output transaction
//  waits, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module line_sensor_array_features
    import lsaf_pkg::*;
#(
    parameter int SENSOR_COUNT  = SENSOR_COUNT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_0 .. sample_N-1, 8 bits each
    input  logic [RAW_W*SENSOR_COUNT-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // lowest_position, lowest_value, lowest_left_value, lowest_right_value,
    // highest_position, highest_value, black line flag, white line flag,
    // black_centroid_near, black_centroid_all, white_centroid_near,
    // white_centroid_all, zero fill to bytes
    output logic [((2*POS_W + 4*(FRACTION_BITS+3) + 2 + 4*(FRACTION_BITS+5) + 7) / 8) * 8 - 1:0]
                                               m_axis_tdata
);

    localparam int SC     = SENSOR_COUNT;
    localparam int F      = FRACTION_BITS;
    localparam int ONE    = 1 << F;
    localparam int VW     = F + 3;        // normalized value
    localparam int CW     = F + 5;        // centroid
    localparam int WW     = VW + 1;       // weight
    localparam int TWD    = F + 9;        // weighted sum
    localparam int BWD    = F + 7;        // weight sum
    localparam int QBN    = F + 2;
    localparam int NWN    = F + 10;
    localparam int DWN    = RAW_W + 1;
    localparam int QBC    = F + 4;
    localparam int NWC    = 2 * F + 10;
    localparam int DWC    = BWD;
    localparam int LN     = (QBN + DIV_STEP - 1) / DIV_STEP;
    localparam int LC     = (QBC + DIV_STEP - 1) / DIV_STEP;
    localparam int TCW    = (VW > THR_W) ? VW : THR_W;
    localparam int FEAT_W = 2 * POS_W + 4 * VW + 2;
    localparam int OUT_W  = ((FEAT_W + 4 * CW + 7) / 8) * 8;

    localparam logic [VW-1:0]        VAL_MAX = VW'(4 * ONE - 1);
    localparam logic [VW-1:0]        VAL_LIM = VW'(4 * ONE);
    localparam logic [CW-1:0]        CEN_MAX = CW'(16 * ONE - 1);
    localparam logic [CW-1:0]        CEN_LIM = CW'(16 * ONE);
    localparam logic signed [WW-1:0] ONE_W   = WW'(ONE);

    // ------------------------------------------------------------------
    // Configuration registers (to be written only while idle; the block does not enforce it)
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]        r_black;
    logic [RAW_W-1:0]        r_white;
    logic signed [THR_W-1:0] r_bthr;
    logic signed [THR_W-1:0] r_wthr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black <= BLACK_LEVEL_RST;
            r_white <= WHITE_LEVEL_RST;
            r_bthr  <= BLACK_THR_RST;
            r_wthr  <= WHITE_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLACK_LEVEL:          r_black <= i_cfg_data[RAW_W-1:0];
                REG_WHITE_LEVEL:          r_white <= i_cfg_data[RAW_W-1:0];
                REG_BLACK_LINE_THRESHOLD: r_bthr  <= i_cfg_data[THR_W-1:0];
                REG_WHITE_LINE_THRESHOLD: r_wthr  <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves unless the result is stuck
    logic r_o_vld;
    logic en;
    assign en            = !r_o_vld || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage A: numerator / denominator magnitudes and signs
    // ------------------------------------------------------------------
    logic [DWN-1:0] den_s, den_abs;
    logic [DWN-1:0] num_s   [SC];
    logic [DWN-1:0] num_abs [SC];

    always_comb begin
        den_s   = {1'b0, r_black} - {1'b0, r_white};
        den_abs = den_s[DWN-1] ? (~den_s + DWN'(1)) : den_s;
        for (int i = 0; i < SC; i++) begin
            num_s[i]   = {1'b0, r_black} - {1'b0, s_axis_tdata[RAW_W*i +: RAW_W]};
            num_abs[i] = num_s[i][DWN-1] ? (~num_s[i] + DWN'(1)) : num_s[i];
        end
    end

    logic             r_a_vld;
    logic [RAW_W-1:0] r_a_un [SC];
    logic [RAW_W-1:0] r_a_ud;
    logic [SC-1:0]    r_a_qneg, r_a_npos, r_a_nneg;
    logic             r_a_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_vld <= 1'b0;
        else if (en)  r_a_vld <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ud <= den_abs[RAW_W-1:0];
            r_a_dz <= (den_s == '0);
            for (int i = 0; i < SC; i++) begin
                r_a_un[i]   <= num_abs[i][RAW_W-1:0];
                r_a_qneg[i] <= num_s[i][DWN-1] ^ den_s[DWN-1];
                r_a_npos[i] <= !num_s[i][DWN-1] && (num_s[i] != '0);
                r_a_nneg[i] <= num_s[i][DWN-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalization dividers: round((un << F) / ud) as floor(N / 2ud)
    // ------------------------------------------------------------------
    logic [NWN-1:0] norm_num [SC];
    logic [DWN-1:0] norm_den;
    logic [QBN-1:0] norm_q   [SC];
    logic [SC-1:0]  norm_ovf;

    assign norm_den = {r_a_ud, 1'b0};

    for (genvar g = 0; g < SC; g++) begin : g_norm
        assign norm_num[g] = (NWN'(r_a_un[g]) << (F + 1)) + NWN'(r_a_ud);
        lsaf_div #(.NW(NWN), .DW(DWN), .QB(QBN), .STEP(DIV_STEP)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (norm_num[g]),
            .i_den  (norm_den),
            .o_quot (norm_q[g]),
            .o_ovf  (norm_ovf[g])
        );
    end

    logic [LN-1:0] r_nd_vld;
    logic [SC-1:0] r_nd_qneg [LN];
    logic [SC-1:0] r_nd_npos [LN];
    logic [SC-1:0] r_nd_nneg [LN];
    logic          r_nd_dz   [LN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nd_vld <= '0;
        else if (en)  r_nd_vld <= LN'({r_nd_vld, r_a_vld});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nd_qneg[0] <= r_a_qneg;
            r_nd_npos[0] <= r_a_npos;
            r_nd_nneg[0] <= r_a_nneg;
            r_nd_dz[0]   <= r_a_dz;
            for (int s = 1; s < LN; s++) begin
                r_nd_qneg[s] <= r_nd_qneg[s-1];
                r_nd_npos[s] <= r_nd_npos[s-1];
                r_nd_nneg[s] <= r_nd_nneg[s-1];
                r_nd_dz[s]   <= r_nd_dz[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: sign, saturation, equal-levels case
    // ------------------------------------------------------------------
    logic [VW-1:0] v_mag [SC];
    logic [VW-1:0] v_new [SC];

    always_comb begin
        for (int i = 0; i < SC; i++) begin
            v_mag[i] = norm_ovf[i] ? VAL_LIM : VW'(norm_q[i]);
            if (r_nd_dz[LN-1]) begin
                if (r_nd_npos[LN-1][i])      v_new[i] = VAL_MAX;
                else if (r_nd_nneg[LN-1][i]) v_new[i] = VAL_LIM;
                else                         v_new[i] = '0;
            end else if (r_nd_qneg[LN-1][i]) begin
                v_new[i] = ~v_mag[i] + VW'(1);
            end else begin
                v_new[i] = (v_mag[i] > VAL_MAX) ? VAL_MAX : v_mag[i];
            end
        end
    end

    logic                 r_b_vld;
    logic signed [VW-1:0] r_b_v [SC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_vld <= 1'b0;
        else if (en)  r_b_vld <= r_nd_vld[LN-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < SC; i++) r_b_v[i] <= v_new[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: first lowest / highest, line flags
    // ------------------------------------------------------------------
    logic [POS_W-1:0]     lo, hi;
    logic signed [VW-1:0] lov, hiv;
    logic                 blk, wht;

    always_comb begin
        lo  = '0;
        hi  = '0;
        lov = r_b_v[0];
        hiv = r_b_v[0];
        for (int i = 1; i < SC; i++) begin
            if (r_b_v[i] < lov) begin
                lo  = POS_W'(i);
                lov = r_b_v[i];
            end else if (r_b_v[i] > hiv) begin
                hi  = POS_W'(i);
                hiv = r_b_v[i];
            end
        end
        blk = 1'b1;
        wht = 1'b1;
        for (int i = 0; i < SC; i++) begin
            if (TCW'(r_b_v[i]) > TCW'(r_bthr)) blk = 1'b0;
            if (TCW'(r_b_v[i]) < TCW'(r_wthr)) wht = 1'b0;
        end
    end

    logic                 r_c_vld;
    logic signed [VW-1:0] r_c_v [SC];
    logic [POS_W-1:0]     r_c_lo, r_c_hi;
    logic signed [VW-1:0] r_c_lov, r_c_hiv;
    logic                 r_c_blk, r_c_wht;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_vld <= 1'b0;
        else if (en)  r_c_vld <= r_b_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < SC; i++) r_c_v[i] <= r_b_v[i];
            r_c_lo  <= lo;
            r_c_hi  <= hi;
            r_c_lov <= lov;
            r_c_hiv <= hiv;
            r_c_blk <= blk;
            r_c_wht <= wht;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: neighbours and weighted sums
    // sum index 0: black near, 1: black all, 2: white near, 3: white all
    // ------------------------------------------------------------------
    logic signed [VW-1:0]  left_v, right_v;
    logic signed [WW-1:0]  wb, ww;
    logic signed [TWD-1:0] tb, tw;
    logic signed [TWD-1:0] top [4];
    logic signed [BWD-1:0] bot [4];
    logic                  near_lo, near_hi;
    logic [FEAT_W-1:0]     feat;

    always_comb begin
        left_v  = -VW'(ONE);
        right_v = -VW'(ONE);
        for (int k = 0; k < 4; k++) begin
            top[k] = '0;
            bot[k] = '0;
        end
        for (int i = 0; i < SC; i++) begin
            if (4'(i) == {1'b0, r_c_lo} + 4'd1) left_v  = r_c_v[i];
            if (4'(i) + 4'd1 == {1'b0, r_c_lo}) right_v = r_c_v[i];
            near_lo = (4'(i) == {1'b0, r_c_lo}) || (4'(i) + 4'd1 == {1'b0, r_c_lo})
                   || (4'(i) == {1'b0, r_c_lo} + 4'd1);
            near_hi = (4'(i) == {1'b0, r_c_hi}) || (4'(i) + 4'd1 == {1'b0, r_c_hi})
                   || (4'(i) == {1'b0, r_c_hi} + 4'd1);
            wb = ONE_W - WW'(r_c_v[i]);
            ww = WW'(r_c_v[i]);
            tb = TWD'(wb) * TWD'(i + 1);
            tw = TWD'(ww) * TWD'(i + 1);
            top[1] = top[1] + tb;
            bot[1] = bot[1] + BWD'(wb);
            top[3] = top[3] + tw;
            bot[3] = bot[3] + BWD'(ww);
            if (near_lo) begin
                top[0] = top[0] + tb;
                bot[0] = bot[0] + BWD'(wb);
            end
            if (near_hi) begin
                top[2] = top[2] + tw;
                bot[2] = bot[2] + BWD'(ww);
            end
        end
        feat = {r_c_wht, r_c_blk, r_c_hiv, r_c_hi, right_v, left_v, r_c_lov, r_c_lo};
    end

    logic                  r_d_vld;
    logic signed [TWD-1:0] r_d_top [4];
    logic signed [BWD-1:0] r_d_bot [4];
    logic [FEAT_W-1:0]     r_d_feat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_vld <= 1'b0;
        else if (en)  r_d_vld <= r_c_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_d_top[k] <= top[k];
                r_d_bot[k] <= bot[k];
            end
            r_d_feat <= feat;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: divider operands
    // ------------------------------------------------------------------
    logic [TWD-1:0] t_abs [4];
    logic [BWD-1:0] b_abs [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            t_abs[k] = r_d_top[k][TWD-1] ? (~r_d_top[k] + TWD'(1)) : r_d_top[k];
            b_abs[k] = r_d_bot[k][BWD-1] ? (~r_d_bot[k] + BWD'(1)) : r_d_bot[k];
        end
    end

    logic           r_e_vld;
    logic [NWC-1:0] r_e_num [4];
    logic [DWC-1:0] r_e_den [4];
    logic [3:0]     r_e_neg, r_e_zero;
    logic [FEAT_W-1:0] r_e_feat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_vld <= 1'b0;
        else if (en)  r_e_vld <= r_d_vld;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_e_num[k]  <= (NWC'(t_abs[k][TWD-2:0]) << (F + 1))
                             + NWC'(b_abs[k][BWD-2:0]);
                r_e_den[k]  <= {b_abs[k][BWD-2:0], 1'b0};
                r_e_neg[k]  <= r_d_top[k][TWD-1] ^ r_d_bot[k][BWD-1];
                r_e_zero[k] <= (r_d_bot[k] == '0);
            end
            r_e_feat <= r_d_feat;
        end
    end

    // ------------------------------------------------------------------
    // Centroid dividers
    // ------------------------------------------------------------------
    logic [QBC-1:0] cen_q [4];
    logic [3:0]     cen_ovf;

    for (genvar g = 0; g < 4; g++) begin : g_cen
        lsaf_div #(.NW(NWC), .DW(DWC), .QB(QBC), .STEP(DIV_STEP)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_e_num[g]),
            .i_den  (r_e_den[g]),
            .o_quot (cen_q[g]),
            .o_ovf  (cen_ovf[g])
        );
    end

    logic [LC-1:0]     r_cd_vld;
    logic [3:0]        r_cd_neg  [LC];
    logic [3:0]        r_cd_zero [LC];
    logic [FEAT_W-1:0] r_cd_feat [LC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cd_vld <= '0;
        else if (en)  r_cd_vld <= LC'({r_cd_vld, r_e_vld});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cd_neg[0]  <= r_e_neg;
            r_cd_zero[0] <= r_e_zero;
            r_cd_feat[0] <= r_e_feat;
            for (int s = 1; s < LC; s++) begin
                r_cd_neg[s]  <= r_cd_neg[s-1];
                r_cd_zero[s] <= r_cd_zero[s-1];
                r_cd_feat[s] <= r_cd_feat[s-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: centroid sign, saturation, zero weight sum
    // ------------------------------------------------------------------
    logic [CW-1:0] c_mag [4];
    logic [CW-1:0] cen   [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            c_mag[k] = cen_ovf[k] ? CEN_LIM : CW'(cen_q[k]);
            if (r_cd_zero[LC-1][k])     cen[k] = '0;
            else if (r_cd_neg[LC-1][k]) cen[k] = ~c_mag[k] + CW'(1);
            else                        cen[k] = (c_mag[k] > CEN_MAX) ? CEN_MAX : c_mag[k];
        end
    end

    logic [OUT_W-1:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_vld <= 1'b0;
        else if (en)  r_o_vld <= r_cd_vld[LC-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_data <= OUT_W'({cen[3], cen[2], cen[1], cen[0], r_cd_feat[LC-1]});
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;

endmodule

>>> bench/line_sensor_array_features_tb.sv
// ----------------------------------------------------------------------------
// line_sensor_array_features_tb
// Self-checking bench for the line sensor feature extractor. Frames go in on
// the input stream and a scoreboard predicts the features of each one from
// its own copy of the level and threshold registers. Each output transaction
// is checked field by field, in order. Registers change only with the
// pipeline empty, over several settings that include the extremes. Both
// stream sides idle at random, except during one long quiet stretch.
// ----------------------------------------------------------------------------
module line_sensor_array_features_tb;
    import lsaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NS   = 8;
    localparam int OUTW = 104;

    // Scoreboard: holds the register copy and the expected feature records.
    class feature_scoreboard;
        int unsigned black_lvl = 0;
        int unsigned white_lvl = 255;
        int          black_thr = 51;
        int          white_thr = 205;
        logic [OUTW-1:0] pending_features[$];
        int errors = 0;
        int    fld_lsb[12] = '{0, 3, 14, 25, 36, 39, 50, 51, 52, 65, 78, 91};
        int    fld_w[12]   = '{3, 11, 11, 11, 3, 11, 1, 1, 13, 13, 13, 13};
        string fld_name[12] = '{"lowest_position", "lowest_value", "lowest_left_value",
            "lowest_right_value", "highest_position", "highest_value",
            "black_line_hit", "white_line_hit", "black_centroid_near",
            "black_centroid_all", "white_centroid_near", "white_centroid_all"};

        // n * 256 / d, rounded half away from zero
        function longint scaled_quotient(longint n, longint d);
            longint un, ud, q;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            q  = ((un << 9) + ud) / (ud * 2);
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function longint weighted_center(longint w[NS], int first, int last);
            longint top, bot, c;
            top = 0;
            bot = 0;
            for (int i = first; i <= last; i++) begin
                top += (i + 1) * w[i];
                bot += w[i];
            end
            if (bot == 0) return 0;
            c = scaled_quotient(top, bot);
            if (c < -4096) c = -4096;
            if (c > 4095) c = 4095;
            return c;
        endfunction

        function void predict_features(logic [RAW_W*NS-1:0] frame);
            longint v[NS], inv[NS];
            longint den, num, q, left_v, right_v;
            int lo, hi;
            logic blk, wht;
            logic [12:0] bcn, bca, wcn, wca;
            logic [10:0] lv, lf, rt, hv;
            logic [2:0] lp, hp;
            den = longint'(black_lvl) - longint'(white_lvl);
            for (int i = 0; i < NS; i++) begin
                num = longint'(black_lvl) - longint'(frame[RAW_W*i +: RAW_W]);
                if (den == 0) begin
                    q = (num > 0) ? 1023 : ((num < 0) ? -1024 : 0);
                end else begin
                    q = scaled_quotient(num, den);
                    if (q < -1024) q = -1024;
                    if (q > 1023) q = 1023;
                end
                v[i] = q;
                inv[i] = 256 - q;
            end
            lo = 0;
            hi = 0;
            for (int i = 1; i < NS; i++) begin
                if (v[i] < v[lo]) lo = i;
                else if (v[i] > v[hi]) hi = i;
            end
            right_v = (lo > 0) ? v[lo-1] : -256;
            left_v  = (lo < NS-1) ? v[lo+1] : -256;
            blk = 1'b1;
            wht = 1'b1;
            for (int i = 0; i < NS; i++) begin
                if (v[i] > black_thr) blk = 1'b0;
                if (v[i] < white_thr) wht = 1'b0;
            end
            lp = lo[2:0];
            hp = hi[2:0];
            lv = v[lo][10:0];
            hv = v[hi][10:0];
            lf = left_v[10:0];
            rt = right_v[10:0];
            bcn = 13'(weighted_center(inv, (lo > 0) ? lo-1 : lo, (lo < NS-1) ? lo+1 : lo));
            bca = 13'(weighted_center(inv, 0, NS-1));
            wcn = 13'(weighted_center(v, (hi > 0) ? hi-1 : hi, (hi < NS-1) ? hi+1 : hi));
            wca = 13'(weighted_center(v, 0, NS-1));
            pending_features.push_back({wca, wcn, bca, bcn, wht, blk, hv, hp, rt, lf, lv, lp});
        endfunction

        function void check_features(logic [OUTW-1:0] got);
            logic [OUTW-1:0] want;
            logic [12:0] e, a;
            if (pending_features.size() == 0) begin
                $display("%0t: unexpected output transaction, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_features.pop_front();
            for (int f = 0; f < 12; f++) begin
                e = 13'((want >> fld_lsb[f]) & ((1 << fld_w[f]) - 1));
                a = 13'((got  >> fld_lsb[f]) & ((1 << fld_w[f]) - 1));
                if (e !== a) begin
                    $display("%0t: %s mismatch, expected %h actual %h",
                             $time, fld_name[f], e, a);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [RAW_W*NS-1:0]     s_axis_tdata;   // sample_0 .. sample_7
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUTW-1:0]         m_axis_tdata;   // feature fields, lowest_position first

    feature_scoreboard sb = new();
    bit quiet = 1'b0;   // set for the stretch with no idling on either side

    line_sensor_array_features dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: check accepted transactions, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_features(m_axis_tdata);
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 24);
    end

    // One frame transaction; valid stays high on return so back-to-back
    // frames never lower and raise it within one step.
    task automatic send_frame(input logic [RAW_W*NS-1:0] frame);
        while (!quiet && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= frame;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_features(frame);
    endtask

    // Hold off until every expected result is out, plus pipeline slack
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_features.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Write all four registers, pipeline idle
    task automatic write_regs(input int bl, input int wl, input int bt, input int wt);
        int vals[4];
        t_cfg_idx idx[4];
        vals = '{bl, wl, bt, wt};
        idx  = '{REG_BLACK_LEVEL, REG_WHITE_LEVEL, REG_BLACK_LINE_THRESHOLD,
                 REG_WHITE_LINE_THRESHOLD};
        drain();
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[r];
            i_cfg_data  <= vals[r][CFG_DATA_W-1:0];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        sb.black_lvl = bl & 8'hFF;
        sb.white_lvl = wl & 8'hFF;
        sb.black_thr = (bt << 21) >>> 21;
        sb.white_thr = (wt << 21) >>> 21;
    endtask

    // Line-shaped frame: a dark or bright spot around a random sensor
    function automatic logic [RAW_W*NS-1:0] line_frame();
        logic [RAW_W*NS-1:0] f;
        int pos, gap, s;
        bit flip;
        pos  = $urandom_range(0, NS-1);
        flip = 1'($urandom_range(0, 1));
        for (int i = 0; i < NS; i++) begin
            gap = (i > pos) ? i - pos : pos - i;
            if (gap == 0) s = $urandom_range(0, 40);
            else if (gap == 1) s = $urandom_range(20, 160);
            else s = $urandom_range(170, 255);
            f[RAW_W*i +: RAW_W] = flip ? 8'(255 - s) : 8'(s);
        end
        return f;
    endfunction

    function automatic logic [RAW_W*NS-1:0] random_frame();
        logic [RAW_W*NS-1:0] f;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) return line_frame();
        if (kind == 6) return {NS{8'($urandom)}};   // all equal, tie breaking
        f = {$urandom, $urandom};
        return f;
    endfunction

    initial begin
        int cfgs[8][4];
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_BLACK_LEVEL;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset register values
        send_frame({NS{8'h00}});
        send_frame({NS{8'hFF}});
        send_frame(64'h0706050403020100);
        send_frame(64'h00FFFFFFFFFFFFFF);   // lowest at the left end
        send_frame(64'hFFFFFFFFFFFFFF00);   // lowest at the right end
        send_frame(64'hFF000000000000FF);   // ties, first position wins
        send_frame(64'h55AA55AA55AA55AA);
        send_frame(64'hAA55AA55AA55AA55);
        send_frame(64'h8080808080808080);
        send_frame(64'h7F7F7F7F7F7F7F7F);
        // Black above white, reversed polarity
        write_regs(255, 0, -1024, 1023);
        send_frame({NS{8'h00}});
        send_frame({NS{8'hFF}});
        send_frame(64'h0001020304FDFEFF);
        // Equal levels: values at the limits or zero
        write_regs(128, 128, 0, 0);
        send_frame(64'h0080FF7F81008000);
        send_frame({NS{8'h80}});
        send_frame({NS{8'hFF}});
        // Close levels: normalization saturates, thresholds at the extremes
        write_regs(100, 101, 1023, -1024);
        send_frame(64'h0064650000FF6563);
        send_frame({NS{8'h64}});
        write_regs(0, 0, -1, 1);
        send_frame({NS{8'h00}});
        send_frame(64'h00000000000000FF);

        cfgs = '{'{0, 255, 51, 205}, '{255, 0, -1024, 1023}, '{40, 220, 30, 230},
                 '{200, 30, 100, -50}, '{255, 255, 1023, -1024}, '{10, 12, 0, 256},
                 '{0, 128, -300, 600}, '{-1, -1, -1, -1}};
        for (int p = 0; p < 8; p++) begin
            if (cfgs[p][0] < 0)
                write_regs($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 2047), $urandom_range(0, 2047));
            else
                write_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3]);
            quiet = (p == 3);
            for (int n = 0; n < 240; n++) send_frame(random_frame());
            quiet = 1'b0;
        end

        drain();
        if (sb.errors == 0)
            $display("line_sensor_array_features_tb OK");
        else
            $display("line_sensor_array_features_tb NOT OK");
        $finish;
    end

    initial begin
        #2ms;
        $display("line_sensor_array_features_tb NOT OK");
        $finish;
    end

endmodule

>>> line_sensor_array_features.f
design/lsaf_pkg.sv
design/lsaf_div.sv
design/line_sensor_array_features.sv
bench/line_sensor_array_features_tb.sv
